### rtl/assert_macros.svh
// assertion macros used by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define SHS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define SHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/shs_pkg.sv
// types and constants of the sha-256 stream hasher
package shs_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int LEN_OFFSET  = 56;
   localparam int ROUNDS      = 64;
   localparam int HASH_WORDS  = 8;
   localparam int WINDOW      = 16;
   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef logic [31:0] word_type;

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam word_type INIT_HASH [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   // source of the byte written into the block
   typedef enum logic [1:0] {
      BYTE_MSG,
      BYTE_MARK,
      BYTE_ZERO,
      BYTE_LEN
   } byte_sel_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic         load_byte;
      byte_sel_type byte_sel;
      logic         push_word;
      logic [2:0]   len_idx;
      logic         count_bits;
      logic         init_work;
      logic         round;
      logic [5:0]   round_idx;
      logic         fold;
      logic         clear;
      logic [2:0]   word_sel;
   } dp_cmd_type;

endpackage

### rtl/shs_stream_if.sv
// handshake channels for message bytes and digest words
interface shs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic       final_byte;

   modport source (output valid, output message_byte, output final_byte, input ready);
   modport sink (input valid, input message_byte, input final_byte, output ready);
endinterface

interface shs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        last_word;

   modport source (output valid, output digest_word, output word_number, output last_word,
                   input ready);
   modport sink (input valid, input digest_word, input word_number, input last_word,
                 output ready);
endinterface

### rtl/sha256_stream_hasher_top.sv
// SHA-256 stream hasher: one message byte per item in, eight digest words out per message.
// A message byte is taken while the hasher is idle. Each 64th byte starts the compression, which
// runs one round per cycle through the single round unit and then folds the result into the
// chaining value; no byte is taken meanwhile. On the final byte the controller writes the
// padding one byte per cycle up to the end of the block, then compresses it; when 56 to 63
// bytes were pending a second padding block follows. The eight digest words then leave one per
// accepted item, word 0 first, and the hasher is ready for the next message right after word 7.
module sha256_stream_hasher_top
   import shs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   shs_req_if.sink   req_if,
   shs_rsp_if.source rsp_if
);

   dp_cmd_type cmd;

   shs_controller u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_final       (req_if.final_byte),
      .req_ready       (req_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_word_number (rsp_if.word_number),
      .rsp_last_word   (rsp_if.last_word),
      .cmd             (cmd)
   );

   shs_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .message_byte (req_if.message_byte),
      .digest_word  (rsp_if.digest_word)
   );

endmodule

### rtl/shs_datapath.sv
// sha-256 datapath: word assembly, schedule window, round logic, chaining value, bit count
module shs_datapath
   import shs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  dp_cmd_type cmd,
   input  logic [7:0] message_byte,
   output word_type   digest_word
);

   function automatic word_type ror(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   logic [23:0] acc_ff, acc_in;
   word_type    w_ff [WINDOW];
   word_type    w_in [WINDOW];
   word_type    v_ff [HASH_WORDS];
   word_type    v_in [HASH_WORDS];
   word_type    h_ff [HASH_WORDS];
   word_type    h_in [HASH_WORDS];
   logic [63:0] bits_ff, bits_in;

   logic [7:0] byte_val;
   logic [5:0] len_shift;
   word_type   new_word, sched_word;
   word_type   big0, big1, ch, maj, t1, t2;

   // length bytes go out most significant first
   assign len_shift = {~cmd.len_idx, 3'b000};

   always_comb begin
      case (cmd.byte_sel)
         BYTE_MSG:  byte_val = message_byte;
         BYTE_MARK: byte_val = PAD_MARK;
         BYTE_LEN:  byte_val = 8'(bits_ff >> len_shift);
         default:   byte_val = 8'h00;
      endcase
   end

   assign new_word = {acc_ff, byte_val};

   assign sched_word = (ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10))
                     + w_ff[9]
                     + (ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3))
                     + w_ff[0];

   assign big1 = ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25);
   assign ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign t1   = v_ff[7] + big1 + ch + ROUND_K[cmd.round_idx] + w_ff[0];
   assign big0 = ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22);
   assign maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t2   = big0 + maj;

   always_comb begin
      acc_in  = acc_ff;
      w_in    = w_ff;
      v_in    = v_ff;
      h_in    = h_ff;
      bits_in = bits_ff;

      if (cmd.load_byte) begin
         acc_in = new_word[23:0];
         if (cmd.push_word) begin
            for (int i = 0; i < WINDOW - 1; i++) w_in[i] = w_ff[i + 1];
            w_in[WINDOW - 1] = new_word;
         end
      end
      if (cmd.count_bits) bits_in = bits_ff + 64'd8;
      if (cmd.init_work) v_in = h_ff;
      if (cmd.round) begin
         for (int i = 0; i < WINDOW - 1; i++) w_in[i] = w_ff[i + 1];
         w_in[WINDOW - 1] = sched_word;
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
      if (cmd.fold) begin
         for (int i = 0; i < HASH_WORDS; i++) h_in[i] = h_ff[i] + v_ff[i];
      end
      if (cmd.clear) begin
         h_in    = INIT_HASH;
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff    <= INIT_HASH;
         bits_ff <= '0;
      end else begin
         h_ff    <= h_in;
         bits_ff <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      w_ff   <= w_in;
      v_ff   <= v_in;
   end

   assign digest_word = h_ff[cmd.word_sel];

endmodule

### rtl/shs_controller.sv
// sha-256 controller: byte intake, padding sequence, round count and digest output
`include "assert_macros.svh"

module shs_controller
   import shs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_final,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_word_number,
   output logic       rsp_last_word,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_ROUND,
      S_FOLD,
      S_OUT
   } state_type;

   localparam logic [5:0] LAST_FILL  = 6'(BLOCK_BYTES - 1);
   localparam logic [5:0] LEN_FILL   = 6'(LEN_OFFSET);
   localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
   localparam logic [2:0] LAST_WORD  = 3'(HASH_WORDS - 1);

   state_type  state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;
   logic       pad_ff, pad_in;     // padding of the current message under way
   logic       mark_ff, mark_in;   // next padding byte is the 0x80 mark
   logic       extra_ff, extra_in; // mark fell into the length field: one more block
   logic       done_ff, done_in;   // block being compressed is the last one
   logic       extra_now;

   assign extra_now = extra_ff | (mark_ff & (fill_ff >= LEN_FILL));

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      round_in = round_ff;
      word_in  = word_ff;
      pad_in   = pad_ff;
      mark_in  = mark_ff;
      extra_in = extra_ff;
      done_in  = done_ff;

      cmd           = '0;
      cmd.byte_sel  = BYTE_ZERO;
      cmd.len_idx   = fill_ff[2:0];
      cmd.round_idx = round_ff;
      cmd.word_sel  = word_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_byte  = 1'b1;
               cmd.byte_sel   = BYTE_MSG;
               cmd.count_bits = 1'b1;
               cmd.push_word  = &fill_ff[1:0];
               if (req_final) begin
                  pad_in  = 1'b1;
                  mark_in = 1'b1;
               end
               if (fill_ff == LAST_FILL) begin
                  cmd.init_work = 1'b1;
                  fill_in       = '0;
                  round_in      = '0;
                  state_in      = S_ROUND;
               end else begin
                  fill_in = fill_ff + 6'd1;
                  if (req_final) state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            cmd.load_byte = 1'b1;
            cmd.push_word = &fill_ff[1:0];
            if (mark_ff) cmd.byte_sel = BYTE_MARK;
            else if (fill_ff >= LEN_FILL && !extra_ff) cmd.byte_sel = BYTE_LEN;
            else cmd.byte_sel = BYTE_ZERO;
            mark_in = 1'b0;
            if (fill_ff == LAST_FILL) begin
               cmd.init_work = 1'b1;
               fill_in       = '0;
               round_in      = '0;
               done_in       = !extra_now;
               extra_in      = 1'b0;
               state_in      = S_ROUND;
            end else begin
               fill_in  = fill_ff + 6'd1;
               extra_in = extra_now;
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) state_in = S_FOLD;
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            if (done_ff) begin
               word_in  = '0;
               state_in = S_OUT;
            end else if (pad_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               word_in = word_ff + 3'd1;
               if (word_ff == LAST_WORD) begin
                  cmd.clear = 1'b1;
                  pad_in    = 1'b0;
                  done_in   = 1'b0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         round_ff <= '0;
         word_ff  <= '0;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         extra_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         word_ff  <= word_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         extra_ff <= extra_in;
         done_ff  <= done_in;
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_word_number = word_ff;
   assign rsp_last_word   = (word_ff == LAST_WORD);

   `SHS_ASSERT_IMPL(a_one_side, clock, reset, req_ready, !rsp_valid,
      "byte intake and digest output overlap")
   `SHS_ASSERT_IMPL(a_fold_after_rounds, clock, reset, state_ff == S_FOLD,
      $past(state_ff) == S_ROUND && $past(round_ff) == LAST_ROUND,
      "fold without a full set of rounds")
   `SHS_ASSERT_IMPL(a_extra_in_pad, clock, reset, extra_ff || done_ff, pad_ff,
      "padding flags set outside padding")
   `SHS_ASSERT_NEXT(a_back_to_idle, clock, reset,
      rsp_valid && rsp_ready && rsp_last_word, req_ready && fill_ff == '0,
      "no return to a fresh message after the last digest word")

endmodule
